// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the lru tag store checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru tag store check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT_RST(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru tag store check failed");

// next-cycle implication, always on
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru tag store check failed");

`endif

// ===== rtl/core/salr_pkg.sv =====
// ----------------------------------------------------------------------------
// salr_pkg
// shared types and constants of the set-associative lru tag store
// ----------------------------------------------------------------------------
package salr_pkg;

  localparam int OP_W      = 3;
  localparam int SET_IN_W  = 6;
  localparam int WAY_IN_W  = 3;
  localparam int TAG_IN_W  = 32;
  localparam int TILE_IN_W = 16;
  localparam int RES_WAY_W = 3;

  localparam int NUM_SETS_DEF   = 64;
  localparam int NUM_WAYS_DEF   = 8;
  localparam int TAG_WIDTH_DEF  = 32;
  localparam int TILE_WIDTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_FIND    = 3'd0,
    OP_PICK    = 3'd1,
    OP_INSTALL = 3'd2,
    OP_TOUCH   = 3'd3,
    OP_RESET   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [RES_WAY_W-1:0] way;
    logic                 victim_valid;
  } res_t;

endpackage

// ===== rtl/core/salr_row_ram.sv =====
// ----------------------------------------------------------------------------
// salr_row_ram
// one row per set, single write port, registered read port
// ----------------------------------------------------------------------------
module salr_row_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/salr_update.sv =====
// ----------------------------------------------------------------------------
// salr_update
// per-set lookup, victim choice, recency update and set clear on one row
// ----------------------------------------------------------------------------
module salr_update #(
  parameter int NUM_WAYS   = salr_pkg::NUM_WAYS_DEF,
  parameter int TAG_WIDTH  = salr_pkg::TAG_WIDTH_DEF,
  parameter int TILE_WIDTH = salr_pkg::TILE_WIDTH_DEF,
  localparam int WAY_W     = $clog2(NUM_WAYS),
  localparam int ROW_W     = NUM_WAYS * (1 + WAY_W + TAG_WIDTH + TILE_WIDTH)
) (
  input  logic [ROW_W-1:0]      row,
  input  salr_pkg::op_t         op,
  input  logic                  set_ok,
  input  logic [WAY_W-1:0]      way_idx,
  input  logic                  way_ok,
  input  logic [TAG_WIDTH-1:0]  tag_val,
  input  logic [TILE_WIDTH-1:0] tile_val,
  output logic [ROW_W-1:0]      new_row,
  output logic [ROW_W-1:0]      clear_row,
  output logic                  wr,
  output salr_pkg::res_t        res
);

  localparam int ROFF = NUM_WAYS;
  localparam int TOFF = ROFF + NUM_WAYS * WAY_W;
  localparam int LOFF = TOFF + NUM_WAYS * TAG_WIDTH;

  logic                  cur_valid [NUM_WAYS];
  logic [WAY_W-1:0]      cur_rank  [NUM_WAYS];
  logic [TAG_WIDTH-1:0]  cur_tag   [NUM_WAYS];
  logic [TILE_WIDTH-1:0] cur_tile  [NUM_WAYS];
  logic                  n_valid   [NUM_WAYS];
  logic [WAY_W-1:0]      n_rank    [NUM_WAYS];
  logic [TAG_WIDTH-1:0]  n_tag     [NUM_WAYS];
  logic [TILE_WIDTH-1:0] n_tile    [NUM_WAYS];

  function automatic logic [salr_pkg::RES_WAY_W-1:0] way3(input logic [WAY_W-1:0] w);
    logic [31:0] e;
    e = 32'(w);
    return e[salr_pkg::RES_WAY_W-1:0];
  endfunction

  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_row
    assign cur_valid[g] = row[g];
    assign cur_rank[g]  = row[ROFF + g*WAY_W +: WAY_W];
    assign cur_tag[g]   = row[TOFF + g*TAG_WIDTH +: TAG_WIDTH];
    assign cur_tile[g]  = row[LOFF + g*TILE_WIDTH +: TILE_WIDTH];

    assign new_row[g]                                = n_valid[g];
    assign new_row[ROFF + g*WAY_W +: WAY_W]          = n_rank[g];
    assign new_row[TOFF + g*TAG_WIDTH +: TAG_WIDTH]  = n_tag[g];
    assign new_row[LOFF + g*TILE_WIDTH +: TILE_WIDTH] = n_tile[g];

    assign clear_row[g]                                = 1'b0;
    assign clear_row[ROFF + g*WAY_W +: WAY_W]          = WAY_W'(g);
    assign clear_row[TOFF + g*TAG_WIDTH +: TAG_WIDTH]  = '0;
    assign clear_row[LOFF + g*TILE_WIDTH +: TILE_WIDTH] = '0;
  end

  always_comb begin
    logic             hit_any;
    logic [WAY_W-1:0] hit_idx;
    logic             any_inv;
    logic [WAY_W-1:0] inv_idx;
    logic [WAY_W-1:0] lru_idx;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] tgt;
    logic [WAY_W-1:0] old_rank;
    logic             mk;

    hit_any = 1'b0;
    hit_idx = '0;
    any_inv = 1'b0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (cur_valid[w] && (cur_tag[w] == tag_val)) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!cur_valid[w]) begin
        any_inv = 1'b1;
        inv_idx = WAY_W'(w);
      end
      if (cur_rank[w] == WAY_W'(NUM_WAYS - 1)) begin
        lru_idx = WAY_W'(w);
      end
    end
    victim = any_inv ? inv_idx : lru_idx;

    for (int w = 0; w < NUM_WAYS; w++) begin
      n_valid[w] = cur_valid[w];
      n_rank[w]  = cur_rank[w];
      n_tag[w]   = cur_tag[w];
      n_tile[w]  = cur_tile[w];
    end
    res = '0;
    wr  = 1'b0;
    mk  = 1'b0;
    tgt = way_idx;

    unique case (op)
      salr_pkg::OP_FIND: begin
        res.found = hit_any;
        res.way   = hit_any ? way3(hit_idx) : '0;
      end
      salr_pkg::OP_PICK: begin
        mk               = 1'b1;
        tgt              = victim;
        wr               = 1'b1;
        res.way          = way3(victim);
        res.victim_valid = !any_inv;
      end
      salr_pkg::OP_INSTALL: begin
        if (way_ok) begin
          n_valid[way_idx] = 1'b1;
          n_tag[way_idx]   = tag_val;
          n_tile[way_idx]  = tile_val;
          mk               = 1'b1;
          wr               = 1'b1;
        end
      end
      salr_pkg::OP_TOUCH: begin
        if (way_ok) begin
          mk = 1'b1;
          wr = 1'b1;
        end
      end
      salr_pkg::OP_RESET: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          n_valid[w] = 1'b0;
          n_rank[w]  = WAY_W'(w);
        end
        wr = 1'b1;
      end
      default: begin
      end
    endcase

    if (mk) begin
      old_rank = cur_rank[tgt];
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (cur_rank[w] < old_rank) begin
          n_rank[w] = cur_rank[w] + WAY_W'(1);
        end
      end
      n_rank[tgt] = '0;
    end else begin
      old_rank = '0;
    end

    if (!set_ok) begin
      wr  = 1'b0;
      res = '0;
    end
  end

endmodule

// ===== rtl/core/set_assoc_lru_replacement.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_replacement
// tag store with true-lru replacement for a set-associative cache
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation set_index way tag tile_id
//   rsp      out        rsp_valid/rsp_stall  found result_way victim_valid
//
// a request is read from the row memory at acceptance and written back when its
// result is registered; one request per cycle when rsp_stall is low, the row
// written back is forwarded to a following request on the same set
// after reset the row memory is cleared one set per cycle, with req_stall
// high; rsp_stall holds the result register and, while a request waits
// behind it, the request channel
// ----------------------------------------------------------------------------
module set_assoc_lru_replacement #(
  parameter int NUM_SETS   = salr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS   = salr_pkg::NUM_WAYS_DEF,
  parameter int TAG_WIDTH  = salr_pkg::TAG_WIDTH_DEF,
  parameter int TILE_WIDTH = salr_pkg::TILE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [salr_pkg::OP_W-1:0]        operation,
  input  logic [salr_pkg::SET_IN_W-1:0]    set_index,
  input  logic [salr_pkg::WAY_IN_W-1:0]    way,
  input  logic [salr_pkg::TAG_IN_W-1:0]    tag,
  input  logic [salr_pkg::TILE_IN_W-1:0]   tile_id,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic                             found,
  output logic [salr_pkg::RES_WAY_W-1:0]   result_way,
  output logic                             victim_valid
);

  localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int ROW_W  = NUM_WAYS * (1 + WAY_W + TAG_WIDTH + TILE_WIDTH);

  salr_pkg::state_t state;
  logic [SET_AW-1:0] clr_idx;

  logic                  p_valid;
  salr_pkg::op_t         p_op;
  logic                  p_set_ok;
  logic [SET_AW-1:0]     p_addr;
  logic [WAY_W-1:0]      p_way;
  logic                  p_way_ok;
  logic [TAG_WIDTH-1:0]  p_tag;
  logic [TILE_WIDTH-1:0] p_tile;
  logic                  fwd;
  logic [ROW_W-1:0]      fwd_row;
  salr_pkg::res_t        rsp_res;

  logic [31:0]           set_ext;
  logic [31:0]           way_ext;
  logic [63:0]           tag_ext;
  logic [31:0]           tile_ext;
  logic [SET_AW-1:0]     in_addr;
  logic                  clearing;
  logic                  p_done;
  logic                  req_acc;
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      cur_row;
  logic [ROW_W-1:0]      new_row;
  logic [ROW_W-1:0]      clear_row;
  logic                  upd_wr;
  salr_pkg::res_t        upd_res;
  logic                  mem_we;
  logic [SET_AW-1:0]     mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;

  assign set_ext  = 32'(set_index);
  assign way_ext  = 32'(way);
  assign tag_ext  = 64'(tag);
  assign tile_ext = 32'(tile_id);
  assign in_addr  = set_ext[SET_AW-1:0];

  assign clearing  = (state == salr_pkg::ST_CLEAR);
  assign p_done    = p_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (p_valid && !p_done);
  assign req_acc   = req_valid && !req_stall;

  assign mem_we    = clearing || (p_done && upd_wr);
  assign mem_waddr = clearing ? clr_idx : p_addr;
  assign mem_wdata = clearing ? clear_row : new_row;
  assign cur_row   = fwd ? fwd_row : rd_row;

  salr_row_ram #(
    .DEPTH (NUM_SETS),
    .AW    (SET_AW),
    .DW    (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (req_acc),
    .raddr (in_addr),
    .rdata (rd_row)
  );

  salr_update #(
    .NUM_WAYS   (NUM_WAYS),
    .TAG_WIDTH  (TAG_WIDTH),
    .TILE_WIDTH (TILE_WIDTH)
  ) u_upd (
    .row       (cur_row),
    .op        (p_op),
    .set_ok    (p_set_ok),
    .way_idx   (p_way),
    .way_ok    (p_way_ok),
    .tag_val   (p_tag),
    .tile_val  (p_tile),
    .new_row   (new_row),
    .clear_row (clear_row),
    .wr        (upd_wr),
    .res       (upd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= salr_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        salr_pkg::ST_CLEAR: begin
          if (clr_idx == SET_AW'(NUM_SETS - 1)) begin
            state <= salr_pkg::ST_RUN;
          end else begin
            clr_idx <= clr_idx + SET_AW'(1);
          end
        end
        salr_pkg::ST_RUN: begin
        end
        default: begin
          state <= salr_pkg::ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      fwd     <= 1'b0;
    end else if (req_acc) begin
      p_valid <= 1'b1;
      fwd     <= p_done && upd_wr && (p_addr == in_addr);
    end else if (p_done) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      p_op     <= salr_pkg::op_t'(operation);
      p_set_ok <= set_ext < 32'(NUM_SETS);
      p_addr   <= in_addr;
      p_way    <= way_ext[WAY_W-1:0];
      p_way_ok <= way_ext < 32'(NUM_WAYS);
      p_tag    <= tag_ext[TAG_WIDTH-1:0];
      p_tile   <= tile_ext[TILE_WIDTH-1:0];
      fwd_row  <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_done) begin
      rsp_res <= upd_res;
    end
  end

  assign found        = rsp_res.found;
  assign result_way   = rsp_res.way;
  assign victim_valid = rsp_res.victim_valid;

endmodule

// ===== rtl/core/salr_checker.sv =====
// ----------------------------------------------------------------------------
// salr_checker
// port-level checks on the lru tag store, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic                           found,
  input logic [salr_pkg::RES_WAY_W-1:0] result_way,
  input logic                           victim_valid
);

  // held beat
  `ASSERT_NEXT_RST(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(found) && $stable(result_way) && $stable(victim_valid))

  // a find hit and a valid victim never share a beat
  `ASSERT_IMPL(a_found_excl, clk, rst, rsp_valid, !(found && victim_valid))

  // set clearing keeps requests out after reset
  `ASSERT_NEXT(a_clear_stall, clk, rst, req_stall)

  // no result survives reset
  `ASSERT_NEXT(a_rst_empty, clk, rst, !rsp_valid)

endmodule

bind set_assoc_lru_replacement salr_checker u_salr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .found        (found),
  .result_way   (result_way),
  .victim_valid (victim_valid)
);

// ===== dv/set_assoc_lru_replacement_test.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_replacement_test
// self-checking bench for the true-lru tag store: a short table of directed
// requests, then random find / pick / install / touch / clear / spare traffic on a few
// busy sets, each response compared field by field with the table or local lru model
// ----------------------------------------------------------------------------
module set_assoc_lru_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS         = salr_pkg::NUM_SETS_DEF;
  localparam int WAYS         = salr_pkg::NUM_WAYS_DEF;
  localparam int OPW          = salr_pkg::OP_W;
  localparam int SETW         = salr_pkg::SET_IN_W;
  localparam int WAYW         = salr_pkg::WAY_IN_W;
  localparam int TAGW         = salr_pkg::TAG_IN_W;
  localparam int TILEW        = salr_pkg::TILE_IN_W;
  localparam int RWW          = salr_pkg::RES_WAY_W;
  localparam int RANDOM_ITEMS = 1180;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [OPW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE_HI = 3'd7;
  localparam salr_pkg::res_t ZERO_RES = '0;

  typedef struct packed {
    logic [OPW-1:0]   op;
    logic [SETW-1:0]  set;
    logic [WAYW-1:0]  way;
    logic [TAGW-1:0]  tag;
    logic [TILEW-1:0] tile;
  } req_t;

  typedef struct {
    req_t           r;
    bit             typed;
    salr_pkg::res_t want;
  } step_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [OPW-1:0]   operation = '0;
  logic [SETW-1:0]  set_index = '0;
  logic [WAYW-1:0]  way = '0;
  logic [TAGW-1:0]  tag = '0;
  logic [TILEW-1:0] tile_id = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic             found;
  logic [RWW-1:0]   result_way;
  logic             victim_valid;

  set_assoc_lru_replacement dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .set_index    (set_index),
    .way          (way),
    .tag          (tag),
    .tile_id      (tile_id),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .result_way   (result_way),
    .victim_valid (victim_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // local copy of the tag store
  logic            held     [SETS][WAYS];
  logic [TAGW-1:0] held_tag [SETS][WAYS];
  logic [2:0]      age      [SETS][WAYS];

  salr_pkg::res_t  pending_rsp[$];
  step_t           plan[$];
  logic [TAGW-1:0] tag_pool[8];
  int              errors;
  int              accepted;
  int              find_hits;
  int              evictions;
  int              set_clears;
  bit              tail;
  bit              gappy;

  function automatic void clear_lines(int s);
    for (int w = 0; w < WAYS; w++) begin
      held[s][w] = 1'b0;
      age[s][w]  = 3'(w);
    end
  endfunction

  function automatic void promote(int s, int w);
    logic [2:0] old;
    old = age[s][w];
    for (int i = 0; i < WAYS; i++)
      if (age[s][i] < old) age[s][i]++;
    age[s][w] = '0;
  endfunction

  function automatic salr_pkg::res_t lru_predict(req_t r);
    salr_pkg::res_t res;
    int             s;
    int             v;
    res = ZERO_RES;
    s   = int'(r.set);
    v   = -1;
    unique case (r.op)
      salr_pkg::OP_FIND: begin
        for (int i = 0; i < WAYS; i++)
          if (!res.found && held[s][i] && held_tag[s][i] == r.tag) begin
            res.found = 1'b1;
            res.way   = RWW'(i);
          end
      end
      salr_pkg::OP_PICK: begin
        for (int i = 0; i < WAYS; i++)
          if (v < 0 && !held[s][i]) v = i;
        if (v < 0) begin
          res.victim_valid = 1'b1;
          for (int i = 0; i < WAYS; i++)
            if (age[s][i] == WAYS - 1) v = i;
        end
        promote(s, v);
        res.way = RWW'(v);
      end
      salr_pkg::OP_INSTALL: begin
        held[s][r.way]     = 1'b1;
        held_tag[s][r.way] = r.tag;
        promote(s, int'(r.way));
      end
      salr_pkg::OP_TOUCH: promote(s, int'(r.way));
      salr_pkg::OP_RESET: clear_lines(s);
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [OPW-1:0] op, int s, int w, logic [TAGW-1:0] t,
                                  logic [TILEW-1:0] tl, bit typed, salr_pkg::res_t want);
    step_t st;
    st.r.op   = op;
    st.r.set  = SETW'(s);
    st.r.way  = WAYW'(w);
    st.r.tag  = t;
    st.r.tile = tl;
    st.typed  = typed;
    st.want   = want;
    plan.push_back(st);
  endfunction

  task automatic offer(req_t r, bit typed, salr_pkg::res_t want);
    salr_pkg::res_t predicted;
    if (!tail && gappy && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= r.op;
    set_index <= r.set;
    way       <= r.way;
    tag       <= r.tag;
    tile_id   <= r.tile;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predicted = lru_predict(r);
    pending_rsp.push_back(typed ? want : predicted);
    accepted++;
    if (r.op == salr_pkg::OP_FIND && predicted.found) find_hits++;
    if (r.op == salr_pkg::OP_PICK && predicted.victim_valid) evictions++;
    if (r.op == salr_pkg::OP_RESET) set_clears++;
  endtask

  task automatic check_field(string what, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // response side: compare every beat against the oldest expected response
  always @(posedge clk) begin
    salr_pkg::res_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got found %0h way %0h victim_valid %0h",
                 $time, found, result_way, victim_valid);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("found", 3'(want.found), 3'(found));
        check_field("result_way", want.way, result_way);
        check_field("victim_valid", 3'(want.victim_valid), 3'(victim_valid));
      end
    end
  end

  // receiver back-pressure, with one long hold-off while requests keep coming
  initial begin : sink
    bit held_off;
    held_off = 1'b0;
    @(negedge rst);
    while (!tail) begin
      if (!held_off && accepted >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    rsp_stall <= 1'b0;
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
    $display("set_assoc_lru_replacement_test: done, errors");
    $finish;
  end

  initial begin : stim
    req_t r;
    int   dice;
    errors     = 0;
    accepted   = 0;
    find_hits  = 0;
    evictions  = 0;
    set_clears = 0;
    tail       = 1'b0;
    gappy      = 1'b1;
    for (int s = 0; s < SETS; s++) clear_lines(s);
    foreach (tag_pool[i]) tag_pool[i] = $urandom();

    //      op                    set way tag            tile      typed expectation
    add_row(salr_pkg::OP_FIND,    0,  0,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(salr_pkg::OP_PICK,    63, 0,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(salr_pkg::OP_INSTALL, 63, 7,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ZERO_RES);
    add_row(salr_pkg::OP_FIND,    63, 0,  32'hFFFF_FFFF, 16'h0,    1'b1,
            salr_pkg::res_t'{1'b1, 3'd7, 1'b0});
    add_row(salr_pkg::OP_TOUCH,   63, 7,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(OP_SPARE_LO,          63, 7,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ZERO_RES);
    add_row(OP_SPARE_LO + 3'd1,   0,  0,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(OP_SPARE_HI,          42, 5,  32'hA5A5_5A5A, 16'h5A5A, 1'b1, ZERO_RES);
    add_row(salr_pkg::OP_INSTALL, 0,  0,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(salr_pkg::OP_FIND,    0,  3,  32'h0,         16'h0,    1'b1,
            salr_pkg::res_t'{1'b1, 3'd0, 1'b0});
    for (int w = 0; w < WAYS; w++)
      add_row(salr_pkg::OP_INSTALL, 1, w, 32'h100 + w,   16'h1234, 1'b0, ZERO_RES);
    add_row(salr_pkg::OP_PICK,    1,  0,  32'h0,         16'h0,    1'b1,
            salr_pkg::res_t'{1'b0, 3'd0, 1'b1});
    add_row(salr_pkg::OP_FIND,    1,  0,  32'h103,       16'h0,    1'b0, ZERO_RES);
    add_row(salr_pkg::OP_TOUCH,   1,  3,  32'h0,         16'h0,    1'b0, ZERO_RES);
    add_row(salr_pkg::OP_PICK,    1,  0,  32'h0,         16'h0,    1'b0, ZERO_RES);
    add_row(salr_pkg::OP_RESET,   1,  6,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ZERO_RES);
    add_row(salr_pkg::OP_PICK,    1,  0,  32'h0,         16'h0,    1'b1, ZERO_RES);
    add_row(salr_pkg::OP_FIND,    1,  0,  32'h105,       16'h0,    1'b1, ZERO_RES);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) offer(plan[i].r, plan[i].typed, plan[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) gappy = 1'($urandom_range(0, 1));
      tail = (i >= RANDOM_ITEMS - CALM_TAIL);
      dice = $urandom_range(0, 99);
      if (dice < 32) r.op = salr_pkg::OP_FIND;
      else if (dice < 48) r.op = salr_pkg::OP_PICK;
      else if (dice < 76) r.op = salr_pkg::OP_INSTALL;
      else if (dice < 92) r.op = salr_pkg::OP_TOUCH;
      else if (dice < 96) r.op = salr_pkg::OP_RESET;
      else r.op = OPW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      r.set  = ($urandom_range(0, 9) < 7) ? SETW'($urandom_range(0, 3))
                                          : SETW'($urandom_range(0, SETS - 1));
      r.way  = WAYW'($urandom_range(0, WAYS - 1));
      r.tag  = ($urandom_range(0, 6) != 0) ? tag_pool[$urandom_range(0, 7)] : $urandom();
      r.tile = TILEW'($urandom_range(0, 16'hFFFF));
      offer(r, 1'b0, ZERO_RES);
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d find hits, %0d evictions of valid lines, %0d set clears",
             accepted, find_hits, evictions, set_clears);
    if (errors == 0)
      $display("set_assoc_lru_replacement_test: done, clean");
    else
      $display("set_assoc_lru_replacement_test: done, errors");
    $finish;
  end

endmodule
